>>> hdl/zobtt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package zobtt_pkg;

  localparam int INDEX_BITS = 16;
  localparam int BANKS      = 2;
  localparam int PIECES     = 16;
  localparam int SQUARES    = 256;

  localparam int ENTRIES   = 1 << INDEX_BITS;
  localparam int ENT_DEPTH = BANKS << INDEX_BITS;
  localparam int EAW       = (ENT_DEPTH > 1) ? $clog2(ENT_DEPTH) : 1;
  localparam int KEY_DEPTH = PIECES * SQUARES;
  localparam int KAW       = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;

  localparam logic [2:0] OP_LOAD_KEY = 3'd0;
  localparam logic [2:0] OP_CLEAR    = 3'd1;
  localparam logic [2:0] OP_TOGGLE   = 3'd2;
  localparam logic [2:0] OP_MOVE     = 3'd3;
  localparam logic [2:0] OP_LOOKUP   = 3'd4;
  localparam logic [2:0] OP_STORE    = 3'd5;

  localparam logic [1:0] KIND_EXACT = 2'd0;
  localparam logic [1:0] KIND_LOWER = 2'd1;
  localparam logic [1:0] KIND_UPPER = 2'd2;

  // Key reads of a move: (piece, from), (piece, to), (captured, to).
  localparam logic [1:0] KEY_STEP_LAST = 2'd2;

  typedef struct packed {
    logic [2:0]         op;
    logic [3:0]         piece;
    logic [3:0]         other_piece;
    logic [7:0]         square_a;
    logic [7:0]         square_b;
    logic [31:0]        key_low;
    logic [63:0]        key_high;
    logic signed [15:0] score_a;
    logic signed [15:0] score_b;
    logic signed [15:0] search_depth;
    logic [1:0]         bound_kind;
    logic               bank;
  } in_word_t;

  typedef struct packed {
    logic               hit;
    logic signed [15:0] score;
  } out_word_t;

  typedef struct packed {
    logic               valid;
    logic [63:0]        check;
    logic [1:0]         kind;
    logic signed [15:0] eval;
    logic signed [15:0] depth;
  } entry_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_KEY,
    ST_KTAIL,
    ST_TREAD,
    ST_DONE
  } state_t;

  function automatic logic key_ok(input logic [3:0] piece, input logic [7:0] square);
    return (int'(piece) < PIECES) && (int'(square) < SQUARES);
  endfunction

  function automatic logic [KAW-1:0] key_addr(input logic [3:0] piece,
                                              input logic [7:0] square);
    return KAW'(KAW'(piece) * KAW'(SQUARES) + KAW'(square));
  endfunction

  function automatic logic [EAW-1:0] ent_addr(input logic bank,
                                              input logic [INDEX_BITS-1:0] slot);
    return (EAW'(bank) << INDEX_BITS) | EAW'(slot);
  endfunction

endpackage

`default_nettype wire

>>> hdl/zobtt_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module zobtt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> hdl/zobtt_judge.sv
`timescale 1ns / 1ps
`default_nettype none

module zobtt_judge (
  input  wire zobtt_pkg::entry_t    entry,
  input  wire logic                 bank_ok,
  input  wire logic [63:0]          hash_long,
  input  wire logic signed [15:0]   alpha,
  input  wire logic signed [15:0]   beta,
  input  wire logic signed [15:0]   need,
  output zobtt_pkg::out_word_t      res
);

  logic match;
  logic use_score;

  assign match = bank_ok && entry.valid && (entry.depth >= need) &&
                 (entry.check == hash_long);

  // A bound entry only settles the search when it falls outside the window.
  always_comb begin
    case (entry.kind)
      zobtt_pkg::KIND_EXACT: use_score = 1'b1;
      zobtt_pkg::KIND_LOWER: use_score = (entry.eval >= beta);
      zobtt_pkg::KIND_UPPER: use_score = (entry.eval <= alpha);
      default:               use_score = 1'b0;
    endcase
  end

  assign res.hit   = match && use_score;
  assign res.score = (match && use_score) ? entry.eval : 16'sd0;

endmodule

`default_nettype wire

>>> hdl/zobrist_transposition_table.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Ports                         Direction  Word
// in       in_valid in_ready in_data     input      zobtt_pkg::in_word_t
// out      out_valid out_ready out_data  output     zobtt_pkg::out_word_t
//
// One word is in work at a time. Key load, hash clear and table store pass
// through EXEC and DONE, lookup adds TREAD, toggle and move step through KEY
// and KTAIL; the single read port of the key memory gives one key read per cycle.
// After reset a clearing pass writes all 131072 (BANKS << INDEX_BITS) table
// entries invalid, with in_ready low.
// A new word is taken while the previous result waits in the output register;
// a stalled output holds the block only at the end of the next word.

module zobrist_transposition_table (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire zobtt_pkg::in_word_t  in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output zobtt_pkg::out_word_t      out_data
);

  localparam int IB  = zobtt_pkg::INDEX_BITS;
  localparam int EAW = zobtt_pkg::EAW;
  localparam int KAW = zobtt_pkg::KAW;

  zobtt_pkg::state_t    state_r, state_nxt;
  zobtt_pkg::in_word_t  item_r, item_nxt;
  zobtt_pkg::out_word_t res_r, res_nxt;
  zobtt_pkg::out_word_t out_data_r, out_data_nxt;
  zobtt_pkg::out_word_t judge_res;
  zobtt_pkg::entry_t    ent_rdata, ent_wdata;
  logic                 out_valid_r, out_valid_nxt;
  logic [31:0]          hash_short_r, hash_short_nxt;
  logic [63:0]          hash_long_r, hash_long_nxt;
  logic [EAW-1:0]       clr_cnt_r, clr_cnt_nxt;
  logic [1:0]           step_r, step_nxt;
  logic                 pend_r, pend_nxt;

  logic                 out_free;
  logic                 bank_ok;
  logic [EAW-1:0]       ent_addr, ent_waddr;
  logic                 ent_we;
  logic [95:0]          key_rdata;
  logic                 key_we;
  logic [KAW-1:0]       key_raddr;
  logic [3:0]           kpiece;
  logic [7:0]           ksquare;
  logic                 ken;

  assign out_free = !out_valid_r || out_ready;
  assign bank_ok  = int'(item_r.bank) < zobtt_pkg::BANKS;
  assign ent_addr = zobtt_pkg::ent_addr(item_r.bank, hash_short_r[IB-1:0]);

  // Key read for the current step of a toggle or move.
  always_comb begin
    kpiece  = item_r.piece;
    ksquare = item_r.square_a;
    if (step_r == 2'd1) begin
      ksquare = item_r.square_b;
    end else if (step_r == zobtt_pkg::KEY_STEP_LAST) begin
      kpiece  = item_r.other_piece;
      ksquare = item_r.square_b;
    end
    ken = zobtt_pkg::key_ok(kpiece, ksquare);
    if (item_r.op == zobtt_pkg::OP_TOGGLE) begin
      ken = ken && (step_r == 2'd0) && (item_r.piece != 4'd0);
    end else if (step_r == zobtt_pkg::KEY_STEP_LAST) begin
      ken = ken && (item_r.other_piece != 4'd0);
    end
  end

  assign key_raddr = zobtt_pkg::key_addr(kpiece, ksquare);
  assign key_we    = (state_r == zobtt_pkg::ST_EXEC) &&
                     (item_r.op == zobtt_pkg::OP_LOAD_KEY) &&
                     zobtt_pkg::key_ok(item_r.piece, item_r.square_a);

  zobtt_ram #(
    .WIDTH(96),
    .DEPTH(zobtt_pkg::KEY_DEPTH)
  ) u_key_ram (
    .clk  (clk),
    .we   (key_we),
    .waddr(zobtt_pkg::key_addr(item_r.piece, item_r.square_a)),
    .wdata({item_r.key_high, item_r.key_low}),
    .raddr(key_raddr),
    .rdata(key_rdata)
  );

  zobtt_ram #(
    .WIDTH($bits(zobtt_pkg::entry_t)),
    .DEPTH(zobtt_pkg::ENT_DEPTH)
  ) u_entry_ram (
    .clk  (clk),
    .we   (ent_we),
    .waddr(ent_waddr),
    .wdata(ent_wdata),
    .raddr(ent_addr),
    .rdata(ent_rdata)
  );

  zobtt_judge u_judge (
    .entry    (ent_rdata),
    .bank_ok  (bank_ok),
    .hash_long(hash_long_r),
    .alpha    (item_r.score_a),
    .beta     (item_r.score_b),
    .need     (item_r.search_depth),
    .res      (judge_res)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      zobtt_pkg::ST_CLEAR: begin
        if (clr_cnt_r == EAW'(zobtt_pkg::ENT_DEPTH - 1)) begin
          state_nxt = zobtt_pkg::ST_IDLE;
        end
      end
      zobtt_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = zobtt_pkg::ST_EXEC;
        end
      end
      zobtt_pkg::ST_EXEC: begin
        case (item_r.op) inside
          zobtt_pkg::OP_TOGGLE, zobtt_pkg::OP_MOVE: state_nxt = zobtt_pkg::ST_KEY;
          zobtt_pkg::OP_LOOKUP:                     state_nxt = zobtt_pkg::ST_TREAD;
          default:                                  state_nxt = zobtt_pkg::ST_DONE;
        endcase
      end
      zobtt_pkg::ST_KEY: begin
        if (step_r == zobtt_pkg::KEY_STEP_LAST) begin
          state_nxt = zobtt_pkg::ST_KTAIL;
        end
      end
      zobtt_pkg::ST_KTAIL: state_nxt = zobtt_pkg::ST_DONE;
      zobtt_pkg::ST_TREAD: state_nxt = zobtt_pkg::ST_DONE;
      zobtt_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = zobtt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = zobtt_pkg::ST_CLEAR;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    in_ready       = 1'b0;
    item_nxt       = item_r;
    res_nxt        = res_r;
    hash_short_nxt = hash_short_r;
    hash_long_nxt  = hash_long_r;
    clr_cnt_nxt    = clr_cnt_r;
    step_nxt       = step_r;
    pend_nxt       = pend_r;
    ent_we         = 1'b0;
    ent_waddr      = ent_addr;
    ent_wdata      = '0;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;
    unique case (state_r) inside
      zobtt_pkg::ST_CLEAR: begin
        ent_we      = 1'b1;
        ent_waddr   = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + EAW'(1);
      end
      zobtt_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          item_nxt = in_data;
        end
      end
      zobtt_pkg::ST_EXEC: begin
        res_nxt  = '0;
        step_nxt = 2'd0;
        pend_nxt = 1'b0;
        if (item_r.op == zobtt_pkg::OP_CLEAR) begin
          hash_short_nxt = '0;
          hash_long_nxt  = '0;
        end
        if (item_r.op == zobtt_pkg::OP_STORE && bank_ok) begin
          ent_we          = 1'b1;
          ent_wdata.valid = 1'b1;
          ent_wdata.check = hash_long_r;
          ent_wdata.kind  = item_r.bound_kind;
          ent_wdata.eval  = item_r.score_a;
          ent_wdata.depth = item_r.search_depth;
        end
      end
      zobtt_pkg::ST_KEY, zobtt_pkg::ST_KTAIL: begin
        // The key read issued last cycle lands now.
        if (pend_r) begin
          hash_short_nxt = hash_short_r ^ key_rdata[31:0];
          hash_long_nxt  = hash_long_r ^ key_rdata[95:32];
        end
        pend_nxt = (state_r == zobtt_pkg::ST_KEY) && ken;
        step_nxt = step_r + 2'd1;
      end
      zobtt_pkg::ST_TREAD: begin
        res_nxt = judge_res;
      end
      zobtt_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= zobtt_pkg::ST_CLEAR;
      clr_cnt_r    <= '0;
      out_valid_r  <= 1'b0;
      hash_short_r <= '0;
      hash_long_r  <= '0;
      step_r       <= '0;
      pend_r       <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
      hash_short_r <= hash_short_nxt;
      hash_long_r  <= hash_long_nxt;
      step_r       <= step_nxt;
      pend_r       <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The table read data used by the judge was addressed in the cycle before, in EXEC.
  a_tread_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == zobtt_pkg::ST_TREAD |-> $past(state_r) == zobtt_pkg::ST_EXEC)
    else $error("table read judged without a preceding read");

  a_hash_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != zobtt_pkg::ST_EXEC && state_r != zobtt_pkg::ST_KEY &&
     state_r != zobtt_pkg::ST_KTAIL) |=> $stable(hash_short_r) && $stable(hash_long_r))
    else $error("hash changed outside an update");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.hit |-> out_data_r.score == 16'sd0)
    else $error("miss carries a nonzero score");

  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == zobtt_pkg::ST_DONE && out_free |=> out_valid_r)
    else $error("finished word not presented");

endmodule

`default_nettype wire

>>> test/zobrist_tt_checker.sv
`timescale 1ns / 1ps

module zobrist_tt_checker
  import zobtt_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire logic      in_ready,
  input  wire in_word_t  in_data,
  input  wire logic      out_valid,
  input  wire logic      out_ready,
  input  wire out_word_t out_data,
  output int             fail_count,
  output int             pending_results
);

  bit [31:0] hash_short_q;
  bit [63:0] hash_long_q;
  bit [31:0] zkey_short [PIECES*SQUARES];
  bit [63:0] zkey_long [PIECES*SQUARES];
  // Table slots that were never stored are simply absent.
  entry_t    tt_slots [int];
  out_word_t result_q [$];

  function automatic void xor_key(input logic [3:0] piece, input logic [7:0] square);
    int k;
    if (int'(piece) >= PIECES || int'(square) >= SQUARES) return;
    k = int'(piece) * SQUARES + int'(square);
    hash_short_q ^= zkey_short[k];
    hash_long_q  ^= zkey_long[k];
  endfunction

  function automatic out_word_t predict_result(input in_word_t w);
    out_word_t r;
    int        slot_idx;
    entry_t    e;
    logic      usable;
    r = '0;
    usable = 1'b0;
    slot_idx = int'(w.bank) * ENTRIES + int'(hash_short_q[INDEX_BITS-1:0]);
    case (w.op)
      OP_LOAD_KEY: begin
        if (int'(w.piece) < PIECES && int'(w.square_a) < SQUARES) begin
          zkey_short[int'(w.piece) * SQUARES + int'(w.square_a)] = w.key_low;
          zkey_long[int'(w.piece) * SQUARES + int'(w.square_a)]  = w.key_high;
        end
      end
      OP_CLEAR: begin
        hash_short_q = '0;
        hash_long_q  = '0;
      end
      OP_TOGGLE: begin
        if (w.piece != 4'd0) xor_key(w.piece, w.square_a);
      end
      OP_MOVE: begin
        // Applying the same move twice takes it back.
        xor_key(w.piece, w.square_a);
        xor_key(w.piece, w.square_b);
        if (w.other_piece != 4'd0) xor_key(w.other_piece, w.square_b);
      end
      OP_LOOKUP: begin
        if (int'(w.bank) < BANKS && tt_slots.exists(slot_idx)) begin
          e = tt_slots[slot_idx];
          if (e.valid && $signed(e.depth) >= $signed(w.search_depth) &&
              e.check == hash_long_q) begin
            case (e.kind)
              KIND_EXACT: usable = 1'b1;
              KIND_LOWER: usable = $signed(e.eval) >= $signed(w.score_b);
              KIND_UPPER: usable = $signed(e.eval) <= $signed(w.score_a);
              default:    usable = 1'b0;
            endcase
            if (usable) begin
              r.hit   = 1'b1;
              r.score = e.eval;
            end
          end
        end
      end
      OP_STORE: begin
        if (int'(w.bank) < BANKS) begin
          e.valid = 1'b1;
          e.check = hash_long_q;
          e.kind  = w.bound_kind;
          e.eval  = w.score_a;
          e.depth = w.search_depth;
          tt_slots[slot_idx] = e;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    out_word_t want;
    int        errs;
    errs = 0;
    if (rst_n) begin
      // Results are compared before the new word is predicted, so a result can
      // never be matched to a word taken at the same edge.
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          $error("result word with nothing expected: hit %0d score %0d",
                 out_data.hit, out_data.score);
          errs++;
        end else begin
          want = result_q.pop_front();
          if (out_data.hit !== want.hit) begin
            $error("hit mismatch: expected %0d, actual %0d", want.hit, out_data.hit);
            errs++;
          end
          if (out_data.score !== want.score) begin
            $error("score mismatch: expected %0d, actual %0d", want.score, out_data.score);
            errs++;
          end
        end
      end
      if (in_valid && in_ready) result_q.push_back(predict_result(in_data));
    end
    fail_count <= fail_count + errs;
    pending_results <= result_q.size();
  end

endmodule

>>> test/zobrist_transposition_table_tb.sv
`timescale 1ns / 1ps

module zobrist_transposition_table_tb;
  import zobtt_pkg::*;

  localparam int ITEM_TARGET = 1700;
  // The limit leaves room for the clearing pass and a slow run of all words,
  // so reaching it means the bench has hung.
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int POOL_SIZE   = 8;
  localparam int MAX_GAP     = 19;

  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;
  localparam logic [1:0] KIND_BAD   = 2'd3;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  int fail_count;
  int pending_results;
  int src_max = MAX_GAP;
  int sink_max = MAX_GAP;
  int items_sent = 0;
  int cycles = 0;

  bit         key_loaded [PIECES*SQUARES];
  logic [11:0] loaded_q [$];
  logic [7:0] square_pool [POOL_SIZE];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  zobrist_transposition_table u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  zobrist_tt_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int draw_gap(input int max_gap);
    return $urandom_range(max_gap, 0);
  endfunction

  // Every field random, so that fields an operation ignores still see both values.
  function automatic in_word_t noise_word(input logic [2:0] op);
    in_word_t w;
    w.op           = op;
    w.piece        = 4'($urandom);
    w.other_piece  = 4'($urandom);
    w.square_a     = 8'($urandom);
    w.square_b     = 8'($urandom);
    w.key_low      = $urandom;
    w.key_high     = {$urandom, $urandom};
    w.score_a      = 16'($urandom);
    w.score_b      = 16'($urandom);
    w.search_depth = 16'($urandom);
    w.bound_kind   = 2'($urandom);
    w.bank         = 1'($urandom);
    return w;
  endfunction

  // Called and returning at a falling edge; valid is lowered only for a gap.
  task automatic send_word(input in_word_t w);
    int gap;
    if ($urandom_range(99, 0) == 0) src_max = (src_max == 0) ? MAX_GAP : 0;
    gap = draw_gap(src_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!(in_valid && in_ready));
    @(negedge clk);
    if (w.op == OP_LOAD_KEY && !key_loaded[{w.piece, w.square_a}]) begin
      key_loaded[{w.piece, w.square_a}] = 1'b1;
      loaded_q.push_back({w.piece, w.square_a});
    end
    if (w.op <= OP_STORE) items_sent++;
  endtask

  task automatic put_op(input logic [2:0] op);
    send_word(noise_word(op));
  endtask

  task automatic put_key(input logic [3:0] piece, input logic [7:0] square,
                         input logic [31:0] lo, input logic [63:0] hi);
    in_word_t w;
    w = noise_word(OP_LOAD_KEY);
    w.piece    = piece;
    w.square_a = square;
    w.key_low  = lo;
    w.key_high = hi;
    send_word(w);
  endtask

  task automatic put_toggle(input logic [3:0] piece, input logic [7:0] square);
    in_word_t w;
    w = noise_word(OP_TOGGLE);
    w.piece    = piece;
    w.square_a = square;
    send_word(w);
  endtask

  task automatic put_move(input logic [3:0] piece, input logic [3:0] other,
                          input logic [7:0] from_sq, input logic [7:0] to_sq);
    in_word_t w;
    w = noise_word(OP_MOVE);
    w.piece       = piece;
    w.other_piece = other;
    w.square_a    = from_sq;
    w.square_b    = to_sq;
    send_word(w);
  endtask

  task automatic put_lookup(input logic bank, input int alpha, input int beta, input int need);
    in_word_t w;
    w = noise_word(OP_LOOKUP);
    w.bank         = bank;
    w.score_a      = 16'(alpha);
    w.score_b      = 16'(beta);
    w.search_depth = 16'(need);
    send_word(w);
  endtask

  task automatic put_store(input logic bank, input logic [1:0] kind,
                           input int eval, input int depth);
    in_word_t w;
    w = noise_word(OP_STORE);
    w.bank         = bank;
    w.bound_kind   = kind;
    w.score_a      = 16'(eval);
    w.search_depth = 16'(depth);
    send_word(w);
  endtask

  function automatic logic [7:0] pool_square();
    return square_pool[$urandom_range(POOL_SIZE - 1, 0)];
  endfunction

  // A search line: moves out, store, probe, moves back, maybe probe the root.
  task automatic play_line();
    logic [3:0] mv_piece [4];
    logic [3:0] mv_other [4];
    logic [7:0] mv_from [4];
    logic [7:0] mv_to [4];
    int         n_moves;
    logic       bk;
    logic [1:0] kind;
    int         ev;
    int         dp;
    n_moves = $urandom_range(4, 1);
    for (int i = 0; i < n_moves; i++) begin
      mv_piece[i] = 4'($urandom);
      mv_other[i] = ($urandom_range(2, 0) == 0) ? 4'd0 : 4'($urandom);
      mv_from[i]  = pool_square();
      mv_to[i]    = pool_square();
      put_move(mv_piece[i], mv_other[i], mv_from[i], mv_to[i]);
    end
    bk   = 1'($urandom);
    kind = ($urandom_range(9, 0) == 0) ? KIND_BAD : 2'($urandom_range(2, 0));
    ev   = int'($urandom_range(65535, 0)) - 32768;
    dp   = ($urandom_range(1, 0) == 0) ? int'($urandom_range(65535, 0)) - 32768
                                       : int'($urandom_range(20, 0));
    put_store(bk, kind, ev, dp);
    repeat ($urandom_range(3, 1)) begin
      if ($urandom_range(4, 0) == 0)
        put_lookup(1'($urandom), int'($urandom_range(65535, 0)) - 32768,
                   int'($urandom_range(65535, 0)) - 32768,
                   int'($urandom_range(65535, 0)) - 32768);
      else
        put_lookup(($urandom_range(5, 0) == 0) ? ~bk : bk,
                   ev + int'($urandom_range(4, 0)) - 2,
                   ev + int'($urandom_range(4, 0)) - 2,
                   dp + 1 - int'($urandom_range(3, 0)));
    end
    for (int i = n_moves - 1; i >= 0; i--) put_move(mv_piece[i], mv_other[i], mv_from[i], mv_to[i]);
    if ($urandom_range(1, 0) == 0) put_op(OP_LOOKUP);
  endtask

  task automatic play_noise();
    logic [2:0]  op;
    logic [11:0] pick;
    in_word_t    w;
    op = 3'($urandom_range(7, 0));
    case (op)
      OP_TOGGLE: begin
        // Piece 0 reads no key, so any square will do.
        if ($urandom_range(5, 0) == 0) begin
          put_toggle(4'd0, 8'($urandom));
        end else begin
          pick = loaded_q[$urandom_range(loaded_q.size() - 1, 0)];
          put_toggle(pick[11:8], pick[7:0]);
        end
      end
      OP_MOVE: begin
        put_move(4'($urandom), 4'($urandom), pool_square(), pool_square());
      end
      OP_LOAD_KEY: begin
        w = noise_word(OP_LOAD_KEY);
        if ($urandom_range(1, 0) == 0) w.square_a = pool_square();
        send_word(w);
      end
      default: put_op(op);
    endcase
  endtask

  initial begin
    int hold;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if ($urandom_range(99, 0) == 0) sink_max = (sink_max == 0) ? MAX_GAP : 0;
      hold = draw_gap(sink_max);
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      @(negedge clk);
    end
  end

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    put_lookup(1'b0, 0, 0, -32768);
    put_key(4'd15, 8'd255, '1, '1);
    // This key leaves the low 16 hash bits, the table index, alone, so it moves the check word but not the slot.
    put_key(4'd1, 8'd0, 32'h0001_0000, 64'h8000_0000_0000_0001);
    put_key(4'd0, 8'd0, $urandom, {$urandom, $urandom});
    put_key(4'd0, 8'd255, '0, '0);
    put_store(1'b1, KIND_EXACT, -32768, 32767);
    put_lookup(1'b1, 0, 0, 32767);
    put_lookup(1'b0, 0, 0, -32768);
    put_toggle(4'd1, 8'd0);
    put_lookup(1'b1, 0, 0, -32768);
    put_toggle(4'd0, 8'd0);
    put_toggle(4'd1, 8'd0);
    put_lookup(1'b1, 32767, -32768, -32768);
    put_store(1'b0, KIND_LOWER, 100, 5);
    put_lookup(1'b0, -32768, 100, 5);
    put_lookup(1'b0, -32768, 101, 5);
    put_lookup(1'b0, -32768, 100, 6);
    put_store(1'b0, KIND_UPPER, 32767, -32768);
    put_lookup(1'b0, 32767, 32767, -32768);
    put_lookup(1'b0, 32766, -32768, -32768);
    put_store(1'b1, KIND_BAD, 7, 0);
    put_lookup(1'b1, 32767, -32768, -32768);
    put_op(OP_SPARE_6);
    put_op(OP_SPARE_7);
    put_toggle(4'd15, 8'd255);
    put_move(4'd0, 4'd15, 8'd0, 8'd255);
    put_move(4'd0, 4'd15, 8'd0, 8'd255);
    put_op(OP_CLEAR);

    // Every piece gets a key on each pool square, so moves among them are legal.
    square_pool[0] = 8'd0;
    square_pool[1] = 8'd255;
    for (int i = 2; i < POOL_SIZE; i++) square_pool[i] = 8'($urandom);
    for (int p = 0; p < PIECES; p++)
      for (int i = 0; i < POOL_SIZE; i++)
        put_key(4'(p), square_pool[i], $urandom, {$urandom, $urandom});

    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(9, 0) < 6) play_line();
      else play_noise();
    end

    in_valid <= 1'b0;
    wait (pending_results == 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/zobtt_pkg.sv
hdl/zobtt_ram.sv
hdl/zobtt_judge.sv
hdl/zobrist_transposition_table.sv
test/zobrist_tt_checker.sv
test/zobrist_transposition_table_tb.sv
